FILE: hdl/mcv_pkg.sv
`timescale 1ns / 1ps

package mcv_pkg;

    // Number formats and pipeline sizing.
    localparam int FRAC_BITS  = 16;
    localparam int MAX_STAGES = 5;
    localparam int NUM_GAINS  = 5;
    localparam int VAL_W      = 24;
    localparam int GAIN_W     = 32;
    localparam int CNT_W      = 3;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 32;
    localparam int WIDE_W     = 48;
    localparam int DIV_NW     = 48;
    localparam int DIV_DW     = 33;
    localparam int GEFF_W     = GAIN_W + 2;
    localparam int ONE_W      = FRAC_BITS + 1;
    localparam int PROD_W     = GAIN_W + 1 + ONE_W;
    localparam int FWD_W      = VAL_W + 2;
    localparam int SCL_W      = FWD_W + VAL_W;
    localparam int DIFF_W     = VAL_W + 1;

    localparam logic [ONE_W-1:0]  ONE_F    = ONE_W'(1) << FRAC_BITS;
    localparam logic [DIV_DW-1:0] DEN_ONE  = DIV_DW'(1) << FRAC_BITS;
    localparam logic [DIV_NW-1:0] FRAC_MAX = (DIV_NW'(1) << FRAC_BITS) - DIV_NW'(1);
    localparam longint VAL_MAX = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
    localparam longint VAL_MIN = -(64'sd1 <<< (VAL_W - 1));
    localparam logic signed [VAL_W-1:0] SCALE_RESET = VAL_W'(1) << FRAC_BITS;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_OFFSET,
        REG_SCALE,
        REG_COUNT,
        REG_GAIN1,
        REG_GAIN2,
        REG_GAIN3,
        REG_GAIN4,
        REG_GAIN5
    } t_reg_idx;

    typedef logic signed [GAIN_W-1:0] t_gain;
    typedef t_gain t_gain_set [NUM_GAINS];

    // Per-item context that rides along with the data through every cell.
    typedef struct packed {
        logic                     act;
        logic                     ovf;
        logic                     skip;
        logic                     on;
        logic                     gneg;
        logic                     qneg;
        logic [CNT_W-1:0]         n;
        logic [CNT_W-1:0]         k;
        logic signed [WIDE_W-1:0] val;
        logic signed [WIDE_W-1:0] sec;
    } t_ctx;

    // State held by one long-division cell.
    typedef struct packed {
        logic [DIV_DW-1:0] rem;
        logic [DIV_NW-1:0] num;
        logic [DIV_NW-1:0] quo;
        logic [DIV_DW-1:0] den;
        t_ctx              ctx;
    } t_div;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic                    overflow;
    } t_res;

endpackage

FILE: hdl/mcv_in_if.sv
`timescale 1ns / 1ps

interface mcv_in_if;
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic signed [mcv_pkg::VAL_W-1:0] in_value;

    modport source (output valid, action, in_value, input ready);
    modport sink (input valid, action, in_value, output ready);
endinterface

FILE: hdl/mcv_out_if.sv
`timescale 1ns / 1ps

interface mcv_out_if;
    logic                    valid;
    logic                    ready;
    logic signed [mcv_pkg::VAL_W-1:0] out_value;
    logic                    overflow;

    modport source (output valid, out_value, overflow, input ready);
    modport sink (input valid, out_value, overflow, output ready);
endinterface

FILE: hdl/mcv_div_cell.sv
`timescale 1ns / 1ps

module mcv_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  mcv_pkg::t_div i_div,
    output logic          o_vld,
    output mcv_pkg::t_div o_div
);

    logic                      r_vld;
    mcv_pkg::t_div             r_div;
    mcv_pkg::t_div             n_div;
    logic [mcv_pkg::DIV_DW:0]  w_trial;
    logic [mcv_pkg::DIV_DW:0]  w_diff;

    // One restoring step: bring in the next numerator bit, subtract if it fits.
    always_comb begin
        n_div     = i_div;
        w_trial   = {i_div.rem, i_div.num[mcv_pkg::DIV_NW-1]};
        w_diff    = w_trial - {1'b0, i_div.den};
        n_div.num = {i_div.num[mcv_pkg::DIV_NW-2:0], 1'b0};
        if (!w_diff[mcv_pkg::DIV_DW]) begin
            n_div.rem = w_diff[mcv_pkg::DIV_DW-1:0];
            n_div.quo = {i_div.quo[mcv_pkg::DIV_NW-2:0], 1'b1};
        end else begin
            n_div.rem = w_trial[mcv_pkg::DIV_DW-1:0];
            n_div.quo = {i_div.quo[mcv_pkg::DIV_NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

FILE: hdl/mcv_div_chain.sv
`timescale 1ns / 1ps

module mcv_div_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [mcv_pkg::DIV_NW-1:0]  i_num,
    input  logic [mcv_pkg::DIV_DW-1:0]  i_den,
    input  mcv_pkg::t_ctx               i_ctx,
    output logic                        o_vld,
    output logic [mcv_pkg::DIV_NW-1:0]  o_quo,
    output mcv_pkg::t_ctx               o_ctx
);

    logic          w_vld [mcv_pkg::DIV_NW+1];
    mcv_pkg::t_div w_div [mcv_pkg::DIV_NW+1];

    // The chain starts with a cleared remainder and quotient.
    always_comb begin
        w_vld[0]     = i_vld;
        w_div[0].rem = '0;
        w_div[0].num = i_num;
        w_div[0].quo = '0;
        w_div[0].den = i_den;
        w_div[0].ctx = i_ctx;
    end

    // One cell per quotient bit.
    for (genvar c = 0; c < mcv_pkg::DIV_NW; c++) begin : g_cell
        mcv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_vld   (w_vld[c]),
            .i_div   (w_div[c]),
            .o_vld   (w_vld[c+1]),
            .o_div   (w_div[c+1])
        );
    end

    assign o_vld = w_vld[mcv_pkg::DIV_NW];
    assign o_quo = w_div[mcv_pkg::DIV_NW].quo;
    assign o_ctx = w_div[mcv_pkg::DIV_NW].ctx;

endmodule

FILE: hdl/mcv_stage.sv
`timescale 1ns / 1ps

module mcv_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [mcv_pkg::CNT_W-1:0]  i_slot,
    input  mcv_pkg::t_gain_set         i_gain,
    input  logic                       i_vld,
    input  mcv_pkg::t_ctx              i_ctx,
    output logic                       o_vld,
    output mcv_pkg::t_ctx              o_ctx
);

    logic [mcv_pkg::CNT_W-1:0]          w_k;
    logic signed [mcv_pkg::WIDE_W-1:0]  w_kv;
    logic signed [mcv_pkg::GEFF_W-1:0]  w_gsel;
    logic signed [mcv_pkg::GEFF_W-1:0]  w_g;
    mcv_pkg::t_ctx                      w_a_ctx;

    logic                               r_a_vld;
    mcv_pkg::t_ctx                      r_a_ctx;
    logic [mcv_pkg::FRAC_BITS-1:0]      r_a_f;
    logic signed [mcv_pkg::GEFF_W-1:0]  r_a_g;

    logic [mcv_pkg::GAIN_W:0]           w_mag;
    logic [mcv_pkg::ONE_W-1:0]          w_sel;
    logic                               r_b_vld;
    mcv_pkg::t_ctx                      r_b_ctx;
    logic [mcv_pkg::FRAC_BITS-1:0]      r_b_f;
    logic [mcv_pkg::PROD_W-1:0]         r_b_m;

    logic [mcv_pkg::DIV_NW-1:0]         w_num1;
    logic [mcv_pkg::DIV_DW-1:0]         w_den1;
    logic                               w_d1_vld;
    logic [mcv_pkg::DIV_NW-1:0]         w_d1_quo;
    mcv_pkg::t_ctx                      w_d1_ctx;
    logic [mcv_pkg::DIV_NW-1:0]         w_fo;

    logic                               r_c_vld;
    mcv_pkg::t_ctx                      r_c_ctx;
    logic signed [mcv_pkg::WIDE_W-1:0]  r_c_t;

    logic [mcv_pkg::DIV_NW-1:0]         w_num2;
    mcv_pkg::t_ctx                      w_c_ctx;
    logic                               w_d2_vld;
    logic [mcv_pkg::DIV_NW-1:0]         w_d2_quo;
    mcv_pkg::t_ctx                      w_d2_ctx;
    logic signed [mcv_pkg::WIDE_W-1:0]  w_res;
    mcv_pkg::t_ctx                      n_o_ctx;

    logic                               r_o_vld;
    mcv_pkg::t_ctx                      r_o_ctx;

    // Section split and effective gain. Inverse items run the stages in
    // reverse order with negated gains; odd sections negate the gain again.
    always_comb begin
        w_k = i_ctx.act ? (i_ctx.n + mcv_pkg::CNT_W'(1) - i_slot) : i_slot;
        w_kv = i_ctx.val * mcv_pkg::WIDE_W'($signed({1'b0, w_k}));
        if (w_k >= mcv_pkg::CNT_W'(1) && w_k <= mcv_pkg::CNT_W'(mcv_pkg::NUM_GAINS)) begin
            w_gsel = mcv_pkg::GEFF_W'(i_gain[w_k - mcv_pkg::CNT_W'(1)]);
        end else begin
            w_gsel = '0;
        end
        w_g = (i_ctx.act ^ w_kv[mcv_pkg::FRAC_BITS]) ? -w_gsel : w_gsel;
        w_a_ctx      = i_ctx;
        w_a_ctx.on   = !i_ctx.skip && (i_slot <= i_ctx.n);
        w_a_ctx.k    = w_k;
        w_a_ctx.gneg = w_g[mcv_pkg::GEFF_W-1];
        w_a_ctx.sec  = $signed({w_kv[mcv_pkg::WIDE_W-1:mcv_pkg::FRAC_BITS],
                                mcv_pkg::FRAC_BITS'(0)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= w_d1_vld;
            r_o_vld <= w_d2_vld;
        end
    end

    // Gain magnitude times either the fraction or its complement.
    always_comb begin
        w_mag = r_a_g[mcv_pkg::GEFF_W-1]
              ? (mcv_pkg::GAIN_W+1)'(0) - r_a_g[mcv_pkg::GAIN_W:0]
              : r_a_g[mcv_pkg::GAIN_W:0];
        w_sel = r_a_ctx.gneg ? {1'b0, r_a_f} : (mcv_pkg::ONE_F - {1'b0, r_a_f});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctx <= w_a_ctx;
            r_a_f   <= w_kv[mcv_pkg::FRAC_BITS-1:0];
            r_a_g   <= w_g;
            r_b_ctx <= r_a_ctx;
            r_b_f   <= r_a_f;
            r_b_m   <= mcv_pkg::PROD_W'(w_mag) * mcv_pkg::PROD_W'(w_sel);
            r_c_ctx <= w_d1_ctx;
            r_c_t   <= w_d1_ctx.sec + $signed(w_fo);
            r_o_ctx <= n_o_ctx;
        end
    end

    // Rational bias: numerator and denominator of the fraction mapping.
    always_comb begin
        w_den1 = mcv_pkg::DEN_ONE
               + mcv_pkg::DIV_DW'(r_b_m >> mcv_pkg::FRAC_BITS);
        w_num1 = (mcv_pkg::DIV_NW'(r_b_f) << mcv_pkg::FRAC_BITS)
               + (r_b_ctx.gneg ? mcv_pkg::DIV_NW'(r_b_m) : mcv_pkg::DIV_NW'(0));
    end

    mcv_div_chain u_bias_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_b_vld),
        .i_num   (w_num1),
        .i_den   (w_den1),
        .i_ctx   (r_b_ctx),
        .o_vld   (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_ctx   (w_d1_ctx)
    );

    // A negative gain can round the mapped fraction up to one; hold it below.
    assign w_fo = (w_d1_ctx.gneg && (w_d1_quo > mcv_pkg::FRAC_MAX)) ? mcv_pkg::FRAC_MAX
                                                                    : w_d1_quo;

    // Floor division by the section count, done on the magnitude.
    always_comb begin
        w_c_ctx      = r_c_ctx;
        w_c_ctx.qneg = r_c_t[mcv_pkg::WIDE_W-1];
        if (r_c_t[mcv_pkg::WIDE_W-1]) begin
            w_num2 = mcv_pkg::DIV_NW'(-r_c_t) + mcv_pkg::DIV_NW'(r_c_ctx.k)
                   - mcv_pkg::DIV_NW'(1);
        end else begin
            w_num2 = mcv_pkg::DIV_NW'(r_c_t);
        end
    end

    mcv_div_chain u_sect_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_c_vld),
        .i_num   (w_num2),
        .i_den   (mcv_pkg::DIV_DW'(r_c_ctx.k)),
        .i_ctx   (w_c_ctx),
        .o_vld   (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_ctx   (w_d2_ctx)
    );

    // Inactive slots pass the value through unchanged.
    always_comb begin
        w_res   = w_d2_ctx.qneg ? -$signed(w_d2_quo) : $signed(w_d2_quo);
        n_o_ctx = w_d2_ctx;
        if (w_d2_ctx.on) begin
            n_o_ctx.val = w_res;
        end
    end

    assign o_vld = r_o_vld;
    assign o_ctx = r_o_ctx;

endmodule

FILE: hdl/monotonic_shaper_curve_eval.sv
`timescale 1ns / 1ps

// Monotonic shaper curve evaluator.
// Input channel i_in carries an action (0 forward, 1 inverse) and a signed
// Q7.16 value; output channel o_out returns one saturated Q7.16 value and an
// overflow flag for every input transaction, in order.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data: offset,
// scale, stage count and the five stage gains. The user must write them only
// while the block is idle; the block itself does not enforce it.
// The datapath is a pipeline built from rows of long-division cells: one
// row for the inverse scale division and two rows in each of the five
// shaper stages, 48 cells each. One transaction enters per cycle while the
// output buffer has room; a result passes the input register, the scale
// division row, the five shaper stages and the product register in turn.
// A two-entry output buffer sits at the end. When the receiver stalls,
// the buffer fills, ready drops on i_in, and the whole pipeline holds its
// contents until a buffer entry is taken.
// Reset (synchronous, active low) empties the pipeline and the buffer and
// loads offset 0, scale 1.0, stage count 0 and all gains 0.
module monotonic_shaper_curve_eval (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mcv_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [mcv_pkg::CFG_W-1:0]   i_cfg_data,
    mcv_in_if.sink                      i_in,
    mcv_out_if.source                   o_out
);

    logic signed [mcv_pkg::VAL_W-1:0]   r_offset;
    logic signed [mcv_pkg::VAL_W-1:0]   r_scale;
    logic [mcv_pkg::CNT_W-1:0]          r_count;
    mcv_pkg::t_gain_set                 r_gain;

    logic                               w_en;
    logic                               r_in_vld;
    logic                               r_in_act;
    logic signed [mcv_pkg::VAL_W-1:0]   r_in_val;

    logic signed [mcv_pkg::DIFF_W-1:0]  w_d;
    logic [mcv_pkg::DIFF_W-1:0]         w_dmag;
    logic [mcv_pkg::VAL_W-1:0]          w_smag;
    mcv_pkg::t_ctx                      w_ctx0;
    logic [mcv_pkg::DIV_NW-1:0]         w_num0;

    logic                               w_d0_vld;
    logic [mcv_pkg::DIV_NW-1:0]         w_d0_quo;
    mcv_pkg::t_ctx                      w_d0_ctx;
    mcv_pkg::t_ctx                      n_f_ctx;
    logic                               r_f_vld;
    mcv_pkg::t_ctx                      r_f_ctx;

    logic                               w_sv [mcv_pkg::MAX_STAGES+1];
    mcv_pkg::t_ctx                      w_sc [mcv_pkg::MAX_STAGES+1];

    logic                               r_p_vld;
    mcv_pkg::t_ctx                      r_p_ctx;
    logic signed [mcv_pkg::SCL_W-1:0]   r_p_prod;

    logic signed [mcv_pkg::SCL_W-1:0]   w_pre;
    mcv_pkg::t_res                      w_res;

    mcv_pkg::t_res                      r_sk_data [2];
    logic                               r_sk_wr;
    logic                               r_sk_rd;
    logic [1:0]                         r_sk_cnt;
    logic                               w_push;
    logic                               w_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_scale  <= mcv_pkg::SCALE_RESET;
            r_count  <= '0;
            for (int g = 0; g < mcv_pkg::NUM_GAINS; g++) begin
                r_gain[g] <= '0;
            end
        end else if (i_cfg_we) begin
            case (mcv_pkg::t_reg_idx'(i_cfg_idx))
                mcv_pkg::REG_OFFSET: r_offset  <= i_cfg_data[mcv_pkg::VAL_W-1:0];
                mcv_pkg::REG_SCALE:  r_scale   <= i_cfg_data[mcv_pkg::VAL_W-1:0];
                mcv_pkg::REG_COUNT:  r_count   <= i_cfg_data[mcv_pkg::CNT_W-1:0];
                mcv_pkg::REG_GAIN1:  r_gain[0] <= i_cfg_data;
                mcv_pkg::REG_GAIN2:  r_gain[1] <= i_cfg_data;
                mcv_pkg::REG_GAIN3:  r_gain[2] <= i_cfg_data;
                mcv_pkg::REG_GAIN4:  r_gain[3] <= i_cfg_data;
                mcv_pkg::REG_GAIN5:  r_gain[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output buffer has room.
    assign w_en       = (r_sk_cnt != 2'd2);
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_f_vld  <= 1'b0;
            r_p_vld  <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_in.valid;
            r_f_vld  <= w_d0_vld;
            r_p_vld  <= w_sv[mcv_pkg::MAX_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_act <= i_in.action;
            r_in_val <= i_in.in_value;
            r_f_ctx  <= n_f_ctx;
            r_p_ctx  <= w_sc[mcv_pkg::MAX_STAGES];
            r_p_prod <= mcv_pkg::SCL_W'(
                            $signed(w_sc[mcv_pkg::MAX_STAGES].val[mcv_pkg::FWD_W-1:0]))
                      * mcv_pkg::SCL_W'(r_scale);
        end
    end

    // Front end: offset removal and the inverse scale division setup.
    always_comb begin
        w_d    = mcv_pkg::DIFF_W'(r_in_val) - mcv_pkg::DIFF_W'(r_offset);
        w_dmag = w_d[mcv_pkg::DIFF_W-1] ? mcv_pkg::DIFF_W'(-w_d) : mcv_pkg::DIFF_W'(w_d);
        w_smag = r_scale[mcv_pkg::VAL_W-1] ? mcv_pkg::VAL_W'(-r_scale)
                                           : mcv_pkg::VAL_W'(r_scale);
        w_num0 = mcv_pkg::DIV_NW'(w_dmag) << mcv_pkg::FRAC_BITS;

        w_ctx0      = '0;
        w_ctx0.act  = r_in_act;
        w_ctx0.skip = r_in_act && (r_scale == '0);
        w_ctx0.ovf  = w_ctx0.skip;
        w_ctx0.qneg = w_d[mcv_pkg::DIFF_W-1] ^ r_scale[mcv_pkg::VAL_W-1];
        w_ctx0.n    = (r_count > mcv_pkg::CNT_W'(mcv_pkg::MAX_STAGES))
                    ? mcv_pkg::CNT_W'(mcv_pkg::MAX_STAGES) : r_count;
        if (w_ctx0.skip) begin
            w_ctx0.val = w_d[mcv_pkg::DIFF_W-1] ? mcv_pkg::WIDE_W'(mcv_pkg::VAL_MIN)
                                                : mcv_pkg::WIDE_W'(mcv_pkg::VAL_MAX);
        end else begin
            w_ctx0.val = mcv_pkg::WIDE_W'(r_in_val);
        end
    end

    mcv_div_chain u_scale_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_in_vld),
        .i_num   (w_num0),
        .i_den   (mcv_pkg::DIV_DW'(w_smag)),
        .i_ctx   (w_ctx0),
        .o_vld   (w_d0_vld),
        .o_quo   (w_d0_quo),
        .o_ctx   (w_d0_ctx)
    );

    // Inverse items take the signed quotient, truncated toward zero.
    always_comb begin
        n_f_ctx = w_d0_ctx;
        if (w_d0_ctx.act && !w_d0_ctx.skip) begin
            n_f_ctx.val = w_d0_ctx.qneg ? -$signed(w_d0_quo) : $signed(w_d0_quo);
        end
    end

    // Row of shaper stages.
    assign w_sv[0] = r_f_vld;
    assign w_sc[0] = r_f_ctx;

    for (genvar s = 0; s < mcv_pkg::MAX_STAGES; s++) begin : g_stage
        mcv_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_slot  (mcv_pkg::CNT_W'(s + 1)),
            .i_gain  (r_gain),
            .i_vld   (w_sv[s]),
            .i_ctx   (w_sc[s]),
            .o_vld   (w_sv[s+1]),
            .o_ctx   (w_sc[s+1])
        );
    end

    // Forward scale and offset, then saturation to the output range.
    always_comb begin
        if (r_p_ctx.act) begin
            w_pre = mcv_pkg::SCL_W'(r_p_ctx.val);
        end else begin
            w_pre = (r_p_prod >>> mcv_pkg::FRAC_BITS) + mcv_pkg::SCL_W'(r_offset);
        end
        w_res.overflow = r_p_ctx.ovf;
        if (w_pre > mcv_pkg::SCL_W'(mcv_pkg::VAL_MAX)) begin
            w_res.out_value = mcv_pkg::VAL_W'(mcv_pkg::VAL_MAX);
            w_res.overflow  = 1'b1;
        end else if (w_pre < mcv_pkg::SCL_W'(mcv_pkg::VAL_MIN)) begin
            w_res.out_value = mcv_pkg::VAL_W'(mcv_pkg::VAL_MIN);
            w_res.overflow  = 1'b1;
        end else begin
            w_res.out_value = w_pre[mcv_pkg::VAL_W-1:0];
        end
    end

    // Two-entry output buffer.
    assign w_push = w_en && r_p_vld;
    assign w_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_wr  <= 1'b0;
            r_sk_rd  <= 1'b0;
            r_sk_cnt <= '0;
        end else begin
            if (w_push) begin
                r_sk_wr <= !r_sk_wr;
            end
            if (w_pop) begin
                r_sk_rd <= !r_sk_rd;
            end
            r_sk_cnt <= r_sk_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_sk_data[r_sk_wr] <= w_res;
        end
    end

    assign o_out.valid     = (r_sk_cnt != '0);
    assign o_out.out_value = r_sk_data[r_sk_rd].out_value;
    assign o_out.overflow  = r_sk_data[r_sk_rd].overflow;

endmodule

FILE: hdl/mcv_checker.sv
`timescale 1ns / 1ps

module mcv_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic signed [mcv_pkg::VAL_W-1:0] i_out_value,
    input logic                             i_out_overflow
);

    // A flagged result always sits at one end of the output range.
    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_overflow) |->
            (i_out_value == mcv_pkg::VAL_W'(mcv_pkg::VAL_MAX)) ||
            (i_out_value == mcv_pkg::VAL_W'(mcv_pkg::VAL_MIN)))
        else $error("overflow flag set on an unsaturated value");

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_out_value) && $stable(i_out_overflow)))
        else $error("output payload changed while stalled");

endmodule

bind monotonic_shaper_curve_eval mcv_checker u_mcv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_value    (o_out.out_value),
    .i_out_overflow (o_out.overflow)
);

FILE: tb/monotonic_shaper_curve_eval_tb.sv
`timescale 1ns / 1ps

module monotonic_shaper_curve_eval_tb;
    import mcv_pkg::*;

    localparam int DRAIN_CYCLES = 600;
    localparam int LONG_HOLD    = 1500;
    localparam longint ONE      = 64'sd1 << FRAC_BITS;

    typedef struct {
        logic                    act;
        logic signed [VAL_W-1:0] val;
    } t_curve_in;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    mcv_in_if  in_if ();
    mcv_out_if out_if ();

    monotonic_shaper_curve_eval i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the curve registers.
    longint    sh_offset = 0;
    longint    sh_scale = ONE;
    int        sh_count = 0;
    longint    sh_gain [NUM_GAINS] = '{default: 0};

    t_curve_in curve_in_q [$];
    t_res      curve_res_q [$];
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_errors = 0;
    int        n_phases = 0;
    bit        no_idle = 1'b0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;

    // Division rounding toward minus infinity.
    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
            q--;
        return q;
    endfunction

    // One shaper stage with k sections and gain g.
    function automatic longint shape_stage(longint v, longint k, longint g);
        longint kv, f, sec, den, fo, a;
        kv  = v * k;
        f   = kv & (ONE - 1);
        sec = kv - f;
        if (sec[FRAC_BITS])
            g = -g;
        if (g >= 0) begin
            den = ONE + floor_div(g * (ONE - f), ONE);
            fo  = floor_div(f * ONE, den);
        end else begin
            a   = -g;
            den = ONE + floor_div(a * f, ONE);
            fo  = floor_div(f * (ONE + a), den);
            if (fo > ONE - 1)
                fo = ONE - 1;
        end
        return floor_div(sec + fo, k);
    endfunction

    // Expected curve result for one input transaction.
    function automatic t_res eval_curve(t_curve_in it);
        longint v;
        int     n;
        bit     ovf;
        t_res   r;
        n   = (sh_count > MAX_STAGES) ? MAX_STAGES : sh_count;
        v   = it.val;
        ovf = 1'b0;
        if (!it.act) begin
            for (int k = 1; k <= n; k++)
                v = shape_stage(v, k, sh_gain[k-1]);
            v = floor_div(v * sh_scale, ONE) + sh_offset;
        end else begin
            v -= sh_offset;
            if (sh_scale == 0) begin
                v   = (v >= 0) ? VAL_MAX : VAL_MIN;
                ovf = 1'b1;
            end else begin
                v = (v * ONE) / sh_scale;
                for (int k = n; k >= 1; k--)
                    v = shape_stage(v, k, -sh_gain[k-1]);
            end
        end
        if (v > VAL_MAX) begin
            v   = VAL_MAX;
            ovf = 1'b1;
        end else if (v < VAL_MIN) begin
            v   = VAL_MIN;
            ovf = 1'b1;
        end
        r.out_value = v[VAL_W-1:0];
        r.overflow  = ovf;
        return r;
    endfunction

    // Driver: presents queued items and records the expected result of each transaction.
    int send_gap = 0;
    always @(posedge i_clk) begin : drive_in
        logic      nv;
        t_curve_in it;
        if (!i_rst_n) begin
            in_if.valid    <= 1'b0;
            in_if.action   <= 1'b0;
            in_if.in_value <= '0;
        end else begin
            nv = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                it.act = in_if.action;
                it.val = in_if.in_value;
                curve_res_q.push_back(eval_curve(it));
                n_sent++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (curve_in_q.size() > 0) begin
                    it = curve_in_q.pop_front();
                    in_if.action   <= it.act;
                    in_if.in_value <= it.val;
                    nv = 1'b1;
                    if (!no_idle && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 18);
                end
            end
            in_if.valid <= nv;
        end
    end

    // Monitor: checks each result transaction and stalls the output at random.
    int stall_cnt = 0;
    always @(posedge i_clk) begin : watch_out
        t_res exp_r;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (curve_res_q.size() == 0) begin
                    $display("%0t: unexpected result value=%h overflow=%b", $time,
                             out_if.out_value, out_if.overflow);
                    n_errors++;
                end else begin
                    exp_r = curve_res_q.pop_front();
                    n_checked++;
                    if (out_if.out_value !== exp_r.out_value) begin
                        $display("%0t: out_value expected %h actual %h", $time,
                                 exp_r.out_value, out_if.out_value);
                        n_errors++;
                    end
                    if (out_if.overflow !== exp_r.overflow) begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 exp_r.overflow, out_if.overflow);
                        n_errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                stall_cnt = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                out_if.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(1, 18) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Register write while the block is idle; the shadow copy follows it.
    task automatic write_reg(t_reg_idx idx, longint data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_OFFSET: sh_offset = longint'($signed(data[VAL_W-1:0]));
            REG_SCALE:  sh_scale  = longint'($signed(data[VAL_W-1:0]));
            REG_COUNT:  sh_count  = int'(data[CNT_W-1:0]);
            default:    sh_gain[idx - REG_GAIN1] = longint'($signed(data[GAIN_W-1:0]));
        endcase
    endtask

    function automatic longint rand_gain();
        case ($urandom_range(0, 3))
            0: return longint'($signed($urandom));
            1: return longint'($signed($urandom_range(0, 262143))) - 131072;
            2: return longint'($signed($urandom_range(0, 4194303))) - 2097152;
            default: return 0;
        endcase
    endfunction

    function automatic longint rand_value();
        if ($urandom_range(0, 1))
            return longint'($signed($urandom_range(0, 16777215))) - 8388608;
        return longint'($signed($urandom_range(0, 1048575))) - 524288;
    endfunction

    task automatic set_curve(longint off, longint scl, longint cnt,
                             longint g1, longint g2, longint g3, longint g4, longint g5);
        write_reg(REG_OFFSET, off);
        write_reg(REG_SCALE, scl);
        write_reg(REG_COUNT, cnt);
        write_reg(REG_GAIN1, g1);
        write_reg(REG_GAIN2, g2);
        write_reg(REG_GAIN3, g3);
        write_reg(REG_GAIN4, g4);
        write_reg(REG_GAIN5, g5);
    endtask

    // Queue corner values in both directions plus random ones, then wait for the drain.
    task automatic run_batch(int n_rand);
        longint    corners [10] = '{0, 1, -1, 65535, 65536, -65536, 32768,
                                    VAL_MAX, VAL_MIN, -32768};
        t_curve_in it;
        foreach (corners[i]) begin
            for (int a = 0; a < 2; a++) begin
                it.act = a[0];
                it.val = corners[i][VAL_W-1:0];
                curve_in_q.push_back(it);
            end
        end
        for (int i = 0; i < n_rand; i++) begin
            it.act = $urandom_range(0, 1);
            it.val = rand_value();
            curve_in_q.push_back(it);
        end
        n_phases++;
        while (curve_in_q.size() > 0 || in_if.valid || curve_res_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        in_if.valid    = 1'b0;
        in_if.action   = 1'b0;
        in_if.in_value = '0;
        out_if.ready   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset curve first, then a sweep of register settings.
        run_batch(120);
        set_curve(0, ONE, 5, 32768, -32768, 65536, -65536, 131072);
        run_batch(200);
        set_curve(12345, ONE, 7, 64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF,
                  -64'sh80000000, 64'sh7FFFFFFF);
        run_batch(200);
        set_curve(VAL_MAX, 0, 2, rand_gain(), rand_gain(), 0, 0, 0);
        run_batch(150);
        write_reg(REG_OFFSET, VAL_MIN);
        run_batch(100);
        set_curve(VAL_MAX, VAL_MIN, 3, rand_gain(), rand_gain(), rand_gain(),
                  rand_gain(), rand_gain());
        run_batch(200);
        set_curve(VAL_MIN, VAL_MAX, 1, -64'sh80000000, 0, 0, 0, 0);
        run_batch(150);
        set_curve(rand_value(), rand_value(), 6, rand_gain(), rand_gain(), rand_gain(),
                  rand_gain(), rand_gain());
        hold_req = 1'b1;
        run_batch(250);
        set_curve(rand_value(), 2 * ONE, 4, rand_gain(), rand_gain(), rand_gain(),
                  rand_gain(), rand_gain());
        run_batch(200);
        no_idle = 1'b1;
        set_curve(rand_value(), -ONE / 2, 5, rand_gain(), rand_gain(), rand_gain(),
                  rand_gain(), rand_gain());
        run_batch(200);

        $display("Covered %0d curve settings, %0d transactions sent, %0d results checked,",
                 n_phases, n_sent, n_checked);
        $display("forward and inverse, zero and extreme scales, one long output stall.");
        if (n_errors == 0)
            $display("monotonic_shaper_curve_eval regression: pass");
        else
            $display("monotonic_shaper_curve_eval regression: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10ms;
        $display("monotonic_shaper_curve_eval regression: fail");
        $finish;
    end

endmodule
